// File: hw/rtl/ostb_pkg.sv
// ----------------------------------------------------------------------------
// ostb_pkg: shared types and constants of the one-shot timer bank
// item layouts, operation codes and the control group that drives the cells
// ----------------------------------------------------------------------------
package ostb_pkg;

    localparam int SLOTS_DEF = 16;

    localparam int TIME_W = 32;
    localparam int ID_W   = 32;
    localparam int KIND_W = 8;
    localparam int TICK_W = 16;
    localparam int DUR_W  = 24;

    // operation codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]        operation;
        logic [TICK_W-1:0] tick_ms;
        logic [DUR_W-1:0]  duration_ms;
        logic [KIND_W-1:0] timer_kind;
        logic [ID_W-1:0]   timer_id;
    } t_in_item;

    typedef struct packed {
        logic              is_event;
        logic [KIND_W-1:0] event_kind;
        logic [ID_W-1:0]   event_id;
        logic [TIME_W-1:0] current_time;
        logic              error;
        logic              last;
    } t_out_item;

    // one stored timer
    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   ident;
    } t_entry;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic put_new;   // cell at the fill count takes the new timer
        logic shift;     // every cell takes its upper neighbor
        logic put_head;  // on shift, the new tail cell takes the head timer
        logic do_mark;   // first matching cell sets its mark
    } t_cell_ctrl;

endpackage

// File: hw/rtl/one_shot_timer_bank.sv
// ----------------------------------------------------------------------------
// one_shot_timer_bank: bank of one-shot timers kept in insertion order
// a chain of slot cells plus a small sequencer that walks it on a tick
// ----------------------------------------------------------------------------
// usage
//   input channel  : i_in_valid / o_in_stall / i_in_item, one operation per item
//   output channel : o_out_valid / i_out_stall / o_out_item, one or more result
//                    items per input item, the final one with last set
//   set, remove and clear: the exec state carries out the item, loads the
//   status item into the output register once that register is free and
//   returns to idle, where the next item can be accepted; the input stalls
//   until then. tick: the exec state updates the time, then the walk state
//   moves each stored timer through the head cell, which fires, drops or
//   rotates it to the tail, then loads the status item (at most SLOTS timers)
//   the output register frees the sequencer from the receiver: while a result
//   waits, the block keeps working until it needs to load the next result
//   when the receiver stalls, exec holds its status, the walk a due timer or status
//   reset: time 0, no timers, last identifier 1 (first new identifier is 2);
//   no clearing pass, the bank is usable right after reset
// ----------------------------------------------------------------------------
module one_shot_timer_bank #(
    parameter int SLOTS = ostb_pkg::SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ostb_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ostb_pkg::t_out_item  o_out_item
);
    import ostb_pkg::*;

    localparam int CNT_W = $clog2(SLOTS+1);
    localparam logic [CNT_W-1:0] SLOTS_CW = CNT_W'(SLOTS);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;

    logic [1:0]        r_state,   n_state;
    t_in_item          r_item;
    logic [TIME_W-1:0] r_now,     n_now;
    logic [ID_W-1:0]   r_last_id, n_last_id;
    logic [CNT_W-1:0]  r_count,   n_count;
    logic [CNT_W-1:0]  r_rem,     n_rem;
    t_out_item         r_out;
    logic              r_out_valid;

    t_cell_ctrl        w_ctrl;
    logic              w_emit;
    t_out_item         w_emit_item;
    logic              w_out_free;
    logic              w_due;
    logic [TIME_W:0]   w_tick_sum;
    logic [TIME_W:0]   w_dl_sum;
    logic [TIME_W-1:0] w_tick_now;
    t_entry            w_new;

    // chain wiring: entries flow down toward cell 0, the found flag flows up
    t_entry            w_entry  [SLOTS];
    logic              w_marked [SLOTS];
    t_entry            w_upper  [SLOTS];
    logic              w_upper_marked [SLOTS];
    logic              w_found  [SLOTS+1];

    assign w_found[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            if (g == SLOTS - 1) begin : g_top
                assign w_upper[g]        = '0;
                assign w_upper_marked[g] = 1'b0;
            end else begin : g_mid
                assign w_upper[g]        = w_entry[g+1];
                assign w_upper_marked[g] = w_marked[g+1];
            end
            ostb_cell #(
                .SLOTS (SLOTS),
                .INDEX (g)
            ) u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctrl         (w_ctrl),
                .i_count        (r_count),
                .i_upper        (w_upper[g]),
                .i_upper_marked (w_upper_marked[g]),
                .i_head         (w_entry[0]),
                .i_new          (w_new),
                .i_rm_id        (r_item.timer_id),
                .i_found        (w_found[g]),
                .o_entry        (w_entry[g]),
                .o_marked       (w_marked[g]),
                .o_found        (w_found[g+1])
            );
        end
    endgenerate

    // saturating time and deadline adders
    assign w_tick_sum = {1'b0, r_now} + {{(TIME_W+1-TICK_W){1'b0}}, r_item.tick_ms};
    assign w_dl_sum   = {1'b0, r_now} + {{(TIME_W+1-DUR_W){1'b0}}, r_item.duration_ms};
    assign w_tick_now = w_tick_sum[TIME_W] ? {TIME_W{1'b1}} : w_tick_sum[TIME_W-1:0];

    always_comb begin
        w_new.deadline = w_dl_sum[TIME_W] ? {TIME_W{1'b1}} : w_dl_sum[TIME_W-1:0];
        w_new.kind     = r_item.timer_kind;
        w_new.ident    = r_last_id + ID_W'(1);
    end

    // head timer fires when its deadline is not after the updated time
    assign w_due      = (w_entry[0].deadline <= r_now);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_last_id   = r_last_id;
        n_count     = r_count;
        n_rem       = r_rem;
        w_ctrl      = '0;
        w_emit      = 1'b0;
        w_emit_item = '0;
        w_emit_item.current_time = r_now;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_item.operation == OP_TICK) begin
                    n_now   = w_tick_now;
                    n_rem   = r_count;
                    n_state = ST_WALK;
                end else if (w_out_free) begin
                    w_emit           = 1'b1;
                    w_emit_item.last = 1'b1;
                    n_state          = ST_IDLE;
                    case (r_item.operation)
                        OP_SET: begin
                            if (r_count == SLOTS_CW) begin
                                w_emit_item.error = 1'b1;
                            end else begin
                                w_ctrl.put_new       = 1'b1;
                                n_count              = r_count + CNT_W'(1);
                                n_last_id            = w_new.ident;
                                w_emit_item.event_id = w_new.ident;
                            end
                        end
                        OP_REMOVE: begin
                            w_ctrl.do_mark = 1'b1;
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (r_rem == '0) begin
                    // every stored timer has passed the head: final status
                    if (w_out_free) begin
                        w_emit           = 1'b1;
                        w_emit_item.last = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end else if (w_marked[0]) begin
                    // removed timer leaves silently
                    w_ctrl.shift = 1'b1;
                    n_count      = r_count - CNT_W'(1);
                    n_rem        = r_rem - CNT_W'(1);
                end else if (w_due) begin
                    if (w_out_free) begin
                        w_emit                 = 1'b1;
                        w_emit_item.is_event   = 1'b1;
                        w_emit_item.event_kind = w_entry[0].kind;
                        w_emit_item.event_id   = w_entry[0].ident;
                        w_ctrl.shift           = 1'b1;
                        n_count                = r_count - CNT_W'(1);
                        n_rem                  = r_rem - CNT_W'(1);
                    end
                end else begin
                    // still pending: rotate it to the tail, order is kept
                    w_ctrl.shift    = 1'b1;
                    w_ctrl.put_head = 1'b1;
                    n_rem           = r_rem - CNT_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_now       <= '0;
            r_last_id   <= ID_W'(1);
            r_count     <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_now     <= n_now;
            r_last_id <= n_last_id;
            r_count   <= n_count;
            r_rem     <= n_rem;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_item <= i_in_item;
        end
        if (w_emit) begin
            r_out <= w_emit_item;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOTS_CW)
        else $error("fill count above slot count");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_rem <= r_count))
        else $error("walk counter exceeds stored timers");

    a_event_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_emit_item.is_event) |-> (r_state == ST_WALK))
        else $error("timer event outside of a tick walk");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_EXEC))
        else $error("accepted item not executed");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |=> (r_count == $past(r_count)))
        else $error("fill count changed while idle");

    a_found_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_found[SLOTS] |-> (r_count != '0))
        else $error("identifier match on an empty bank");

endmodule

// File: hw/rtl/ostb_cell.sv
// ----------------------------------------------------------------------------
// ostb_cell: one timer slot of the chain
// holds one timer and its mark, shifts toward the head, matches remove ids
// ----------------------------------------------------------------------------
module ostb_cell #(
    parameter int SLOTS = ostb_pkg::SLOTS_DEF,
    parameter int INDEX = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ostb_pkg::t_cell_ctrl               i_ctrl,
    input  logic [$clog2(SLOTS+1)-1:0]         i_count,
    input  ostb_pkg::t_entry                   i_upper,
    input  logic                               i_upper_marked,
    input  ostb_pkg::t_entry                   i_head,
    input  ostb_pkg::t_entry                   i_new,
    input  logic [ostb_pkg::ID_W-1:0]          i_rm_id,
    input  logic                               i_found,
    output ostb_pkg::t_entry                   o_entry,
    output logic                               o_marked,
    output logic                               o_found
);
    import ostb_pkg::*;

    localparam int CNT_W = $clog2(SLOTS+1);
    localparam logic [CNT_W-1:0] MY_IX   = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] NEXT_IX = CNT_W'(INDEX + 1);

    t_entry r_entry;
    logic   r_marked;
    logic   w_valid;
    logic   w_hit;

    assign w_valid  = (MY_IX < i_count);
    assign w_hit    = w_valid && (r_entry.ident == i_rm_id);
    assign o_found  = i_found | w_hit;
    assign o_entry  = r_entry;
    assign o_marked = r_marked;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.put_new && (i_count == MY_IX)) begin
            r_entry <= i_new;
        end else if (i_ctrl.shift) begin
            if (i_ctrl.put_head && (i_count == NEXT_IX)) begin
                r_entry <= i_head;
            end else begin
                r_entry <= i_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marked <= 1'b0;
        end else if (i_ctrl.put_new && (i_count == MY_IX)) begin
            r_marked <= 1'b0;
        end else if (i_ctrl.shift) begin
            if (i_ctrl.put_head && (i_count == NEXT_IX)) begin
                r_marked <= 1'b0;
            end else begin
                r_marked <= i_upper_marked;
            end
        end else if (i_ctrl.do_mark && w_hit && !i_found) begin
            r_marked <= 1'b1;
        end
    end

endmodule

// File: tb/timer_bank_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_bank_checker: result predictor and comparator for the timer bank
// mirrors the bank state on every accepted input item, queues the results
// it should produce and compares each accepted result field by field
// ----------------------------------------------------------------------------
module timer_bank_checker #(
    parameter int SLOTS = ostb_pkg::SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  ostb_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  ostb_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending
);
    import ostb_pkg::*;

    // mirrored bank state
    logic [TIME_W-1:0] now_time;
    logic [ID_W-1:0]   last_ident;
    t_entry            timers [SLOTS];
    logic              live   [SLOTS];
    logic              marked [SLOTS];

    t_out_item expected_results [$];
    int        fail_total    = 0;
    int        pending_total = 0;
    logic      result_bad;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    function automatic logic [TIME_W-1:0] time_add_clamped(
        input logic [TIME_W-1:0] a,
        input logic [TIME_W-1:0] b
    );
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

    task automatic queue_result(input logic is_event, input logic [KIND_W-1:0] kind,
                                input logic [ID_W-1:0] ident, input logic error,
                                input logic last);
        t_out_item res;
        res.is_event     = is_event;
        res.event_kind   = kind;
        res.event_id     = ident;
        res.current_time = now_time;
        res.error        = error;
        res.last         = last;
        expected_results.insert(expected_results.size(), res);
    endtask

    task automatic clear_timers();
        for (int s = 0; s < SLOTS; s++) begin
            live[s]   = 1'b0;
            marked[s] = 1'b0;
        end
    endtask

    task automatic predict_bank_step(input t_in_item item);
        int   keep;
        int   free_slot;
        logic found;
        keep      = 0;
        free_slot = -1;
        found     = 1'b0;
        case (item.operation)
            OP_TICK: begin
                now_time = time_add_clamped(now_time, TIME_W'(item.tick_ms));
                // walk in insertion order, dropping marked and firing due timers
                for (int s = 0; s < SLOTS; s++) begin
                    if (live[s] && !marked[s]) begin
                        if (timers[s].deadline <= now_time) begin
                            queue_result(1'b1, timers[s].kind, timers[s].ident, 1'b0, 1'b0);
                        end else begin
                            timers[keep] = timers[s];
                            keep++;
                        end
                    end
                end
                for (int s = 0; s < SLOTS; s++) begin
                    live[s]   = (s < keep);
                    marked[s] = 1'b0;
                end
                queue_result(1'b0, '0, '0, 1'b0, 1'b1);
            end
            OP_SET: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (!live[s] && free_slot < 0) free_slot = s;
                end
                if (free_slot < 0) begin
                    queue_result(1'b0, '0, '0, 1'b1, 1'b1);
                end else begin
                    last_ident = last_ident + ID_W'(1);
                    timers[free_slot].deadline =
                        time_add_clamped(now_time, TIME_W'(item.duration_ms));
                    timers[free_slot].kind  = item.timer_kind;
                    timers[free_slot].ident = last_ident;
                    live[free_slot]         = 1'b1;
                    marked[free_slot]       = 1'b0;
                    queue_result(1'b0, '0, last_ident, 1'b0, 1'b1);
                end
            end
            OP_REMOVE: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (!found && live[s] && timers[s].ident == item.timer_id) begin
                        marked[s] = 1'b1;
                        found     = 1'b1;
                    end
                end
                queue_result(1'b0, '0, '0, 1'b0, 1'b1);
            end
            default: begin
                clear_timers();
                queue_result(1'b0, '0, '0, 1'b0, 1'b1);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            result_bad = 1'b1;
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            $display("%0t: result expected none actual %h", $time, got);
            fail_total++;
        end else begin
            want       = expected_results.pop_front();
            result_bad = 1'b0;
            check_field("is_event", 32'(want.is_event), 32'(got.is_event));
            check_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
            check_field("event_id", want.event_id, got.event_id);
            check_field("current_time", want.current_time, got.current_time);
            check_field("error", 32'(want.error), 32'(got.error));
            check_field("last", 32'(want.last), 32'(got.last));
            if (result_bad) fail_total++;
        end
    endtask

    // results of earlier items leave before a new item's results can arrive
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            now_time   = '0;
            last_ident = ID_W'(1);
            clear_timers();
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result(i_out_item);
            if (i_in_valid && !i_in_stall) predict_bank_step(i_in_item);
        end
        pending_total = expected_results.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the one-shot timer bank
// directed corner items followed by a long random mix of set, remove, tick
// and clear, with a long receiver hold-off and a full drain in between
// ----------------------------------------------------------------------------
module testbench;
    import ostb_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AT_ITEM  = 150;
    localparam int PAUSE_AT_ITEM = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int TIMEOUT_NS    = 10_000_000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      in_valid    = 1'b0;
    t_in_item  in_item     = '0;
    logic      out_stall   = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    int fail_count;
    int pending;

    // hold_wanted is set by the sender, hold_done is kept by the receiver process
    logic hold_wanted = 1'b0;
    logic hold_done   = 1'b0;

    int burst_left = 0;
    int sets_sent  = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    one_shot_timer_bank u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    timer_bank_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (o_out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // every field starts as noise so unused fields are exercised too
    function automatic t_in_item noisy_item(input logic [1:0] op);
        t_in_item it;
        it.operation   = op;
        it.tick_ms     = TICK_W'($urandom);
        it.duration_ms = DUR_W'($urandom);
        it.timer_kind  = KIND_W'($urandom);
        it.timer_id    = ID_W'($urandom);
        return it;
    endfunction

    // valid goes up at the falling edge and stays until the item is taken
    task automatic send_item(input t_in_item it);
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (it.operation == OP_SET) sets_sent++;
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
    endtask

    // bursts of random length with random gaps, some bursts back to back
    task automatic offer(input t_in_item it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
        end
        burst_left--;
        send_item(it);
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (pending != 0) idle_cycles(1);
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        int       shape;
        pick  = $urandom_range(0, 99);
        shape = $urandom_range(0, 9);
        if (pick < 40) begin
            it = noisy_item(OP_SET);
            // mostly short timers so that ticks fire them, some far off
            if (shape < 7) it.duration_ms = DUR_W'($urandom_range(0, 3000));
            else if (shape == 9) it.duration_ms = '0;
        end else if (pick < 65) begin
            it = noisy_item(OP_TICK);
            if (shape < 7) it.tick_ms = TICK_W'($urandom_range(0, 800));
            else if (shape == 9) it.tick_ms = '0;
        end else if (pick < 92) begin
            it = noisy_item(OP_REMOVE);
            // mostly identifiers handed out so far, live or already gone
            if (shape < 8) it.timer_id = ID_W'($urandom_range(2, sets_sent + 1));
            else if (shape == 8) it.timer_id = ID_W'($urandom_range(0, 1));
        end else begin
            it = noisy_item(OP_CLEAR);
        end
        return it;
    endfunction

    // receiver: stall pattern of its own, plus one long hold-off on request
    initial begin : receiver
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 3);
            span = (mode == 3) ? $urandom_range(1, 12) : $urandom_range(4, 40);
            for (int c = 0; c < span; c++) begin
                @(negedge i_clk);
                if (hold_wanted && !hold_done) begin
                    // long hold-off so the block fills and stalls its input
                    hold_done = 1'b1;
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                end else begin
                    case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 1) == 0);
                        2:       out_stall <= ($urandom_range(0, 3) != 0);
                        default: out_stall <= 1'b1;
                    endcase
                end
            end
        end
    end

    initial begin : stimulus
        t_in_item it;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: fill the table with extreme durations and kinds
        it = noisy_item(OP_SET);
        it.duration_ms = '0;
        it.timer_kind  = '0;
        offer(it);                                  // first identifier, due at once
        it = noisy_item(OP_SET);
        it.duration_ms = '1;
        it.timer_kind  = '1;
        offer(it);
        for (int s = 2; s < SLOTS_DEF; s++) begin
            it = noisy_item(OP_SET);
            it.duration_ms = DUR_W'(s * 100);
            offer(it);
        end
        offer(noisy_item(OP_SET));                  // table full, refused
        it = noisy_item(OP_REMOVE);
        it.timer_id = ID_W'(3);
        offer(it);
        offer(it);                                  // marking twice changes nothing
        it.timer_id = '1;
        offer(it);                                  // unknown identifiers
        it.timer_id = '0;
        offer(it);
        it = noisy_item(OP_TICK);
        it.tick_ms = '0;
        offer(it);                                  // zero tick still fires the due timer
        it.tick_ms = '1;
        offer(it);                                  // fires everything short
        it = noisy_item(OP_SET);
        it.duration_ms = DUR_W'(100);
        offer(it);
        offer(noisy_item(OP_CLEAR));
        it = noisy_item(OP_TICK);
        it.tick_ms = '0;
        offer(it);                                  // empty bank

        // --- random mix
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT_ITEM) begin
                // keep offering back to back while the receiver holds off
                hold_wanted = 1'b1;
                burst_left  = 40;
            end
            if (n == PAUSE_AT_ITEM) wait_drained();
            offer(random_item());
        end

        // --- tail: longest and shortest durations, then ticks
        it = noisy_item(OP_SET);
        it.duration_ms = '1;
        offer(it);
        it.duration_ms = '0;
        offer(it);
        it = noisy_item(OP_TICK);
        it.tick_ms = '0;
        offer(it);                                  // zero-duration timer is due
        it.tick_ms = '1;
        offer(it);

        // --- drain and verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/ostb_pkg.sv
hw/rtl/ostb_cell.sv
hw/rtl/one_shot_timer_bank.sv
tb/timer_bank_checker.sv
tb/testbench.sv
